// File: rtl/tdsg_pkg.sv
// Shared types, constants and phase tables for the three-axis DDA step generator.
`timescale 1ns / 1ps

package tdsg_pkg;

    localparam int DEF_STEP_BITS     = 24;
    localparam int DEF_POSITION_BITS = 32;

    localparam int DELTA_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int POS_OUT_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_OUT_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SW_ACT_LOW = 3'd5;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_ZERO  = 2'd2
    } mode_t;

    // Per-axis control for one transfer in flight
    typedef struct packed {
        logic start;
        logic tick;
        logic zero;
        logic dir;
        logic drive;
        logic blocked;
    } axis_ctrl_t;

    // Gray phase: 00 -> 01 -> 11 -> 10 -> 00
    function automatic logic [1:0] phase_up(input logic [1:0] p);
        logic [1:0] r;
        unique case (p)
            2'b00:   r = 2'b01;
            2'b01:   r = 2'b11;
            2'b11:   r = 2'b10;
            default: r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] phase_down(input logic [1:0] p);
        logic [1:0] r;
        unique case (p)
            2'b00:   r = 2'b10;
            2'b10:   r = 2'b11;
            2'b11:   r = 2'b01;
            default: r = 2'b00;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/three_axis_dda_step_generator_core.sv
// Top level of the three-axis DDA step generator: handshakes, config and result register.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// -------   ------------------   -----------------------------------------------
// in        in_valid / in_stall   mode, limit_min, limit_max
// out       out_valid / out_stall x/y/z_phase, stepped, moving, x/y/z_position
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while out_stall is low; an item passes the input register,
// then the axis update and the result register in the same edge.
// Reset clears axis state, major count and config to defaults (z output
// enable and active-low switches set). cfg_ready is always high.
// A stalled result holds the result register and, in turn, the input register;
// in_stall rises only while the input register is full and cannot drain.

module three_axis_dda_step_generator_core
    import tdsg_pkg::*;
#(
    parameter int STEP_BITS     = DEF_STEP_BITS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // item input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [2:0]                  limit_min,
    input  logic [2:0]                  limit_max,
    // result output
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  x_phase,
    output logic [1:0]                  y_phase,
    output logic [1:0]                  z_phase,
    output logic [2:0]                  stepped,
    output logic                        moving,
    output logic signed [POS_OUT_W-1:0] x_position,
    output logic signed [POS_OUT_W-1:0] y_position,
    output logic signed [POS_OUT_W-1:0] z_position,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int ACC_BITS = STEP_BITS + 2;

    // ---------------- configuration ----------------
    logic [DELTA_W-1:0] delta_x_reg, delta_y_reg, delta_z_reg;
    logic [2:0]         direction_reg;
    logic               z_out_en_reg;
    logic               sw_act_low_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            delta_z_reg    <= '0;
            direction_reg  <= '0;
            z_out_en_reg   <= 1'b1;
            sw_act_low_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DELTA_X:    delta_x_reg    <= cfg_data;
                CFG_DELTA_Y:    delta_y_reg    <= cfg_data;
                CFG_DELTA_Z:    delta_z_reg    <= cfg_data;
                CFG_DIRECTION:  direction_reg  <= cfg_data[2:0];
                CFG_Z_OUT_EN:   z_out_en_reg   <= cfg_data[0];
                CFG_SW_ACT_LOW: sw_act_low_reg <= cfg_data[0];
                default:        ; // unmapped index, dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic       in_vld_reg;
    logic [1:0] mode_reg;
    logic [2:0] lmin_reg, lmax_reg;
    logic       out_vld_reg;
    logic       adv;     // result register can take a new value
    logic       fire;    // item in input register is processed this cycle

    assign adv      = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && adv;
    assign in_stall = in_vld_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= mode;
            lmin_reg <= limit_min;
            lmax_reg <= limit_max;
        end
    end

    // ---------------- move setup ----------------
    logic                 is_tick, is_start, is_zero;
    logic [STEP_BITS-1:0] dx, dy, dz;
    logic [STEP_BITS-1:0] major_reg, major_next, max_xy;
    logic [ACC_BITS-1:0]  preset;

    assign is_tick  = fire && (mode_reg == MODE_TICK);
    assign is_start = fire && (mode_reg == MODE_START);
    assign is_zero  = fire && (mode_reg == MODE_ZERO);

    assign dx = STEP_BITS'(delta_x_reg);
    assign dy = STEP_BITS'(delta_y_reg);
    assign dz = STEP_BITS'(delta_z_reg);

    assign max_xy     = (dy > dx) ? dy : dx;
    assign major_next = (dz > max_xy) ? dz : max_xy;
    // accumulators start at minus half the major count
    assign preset     = ACC_BITS'(0) - ACC_BITS'(major_next >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg <= '0;
        end
        else if (is_start)
        begin
            major_reg <= major_next;
        end
    end

    // ---------------- axes ----------------
    axis_ctrl_t               ctrl_x, ctrl_y, ctrl_z;
    logic [2:0]               press_min, press_max;
    logic [2:0]               allowed_v, stepped_v;
    logic [1:0]               ph_x, ph_y, ph_z;
    logic [POSITION_BITS-1:0] pos_x, pos_y, pos_z;

    // raw level XOR sense gives "pressed"
    assign press_min = lmin_reg ^ {3{sw_act_low_reg}};
    assign press_max = lmax_reg ^ {3{sw_act_low_reg}};

    always_comb
    begin
        ctrl_x.start   = is_start;
        ctrl_x.tick    = is_tick;
        ctrl_x.zero    = is_zero;
        ctrl_x.dir     = direction_reg[0];
        ctrl_x.drive   = 1'b1;
        ctrl_x.blocked = direction_reg[0] ? press_max[0] : press_min[0];

        ctrl_y.start   = is_start;
        ctrl_y.tick    = is_tick;
        ctrl_y.zero    = is_zero;
        ctrl_y.dir     = direction_reg[1];
        ctrl_y.drive   = 1'b1;
        ctrl_y.blocked = direction_reg[1] ? press_max[1] : press_min[1];

        ctrl_z.start   = is_start;
        ctrl_z.tick    = is_tick;
        ctrl_z.zero    = is_zero;
        ctrl_z.dir     = direction_reg[2];
        ctrl_z.drive   = z_out_en_reg;   // z steps count but phase holds when off
        ctrl_z.blocked = direction_reg[2] ? press_max[2] : press_min[2];
    end

    tdsg_axis #(.STEP_BITS(STEP_BITS), .POSITION_BITS(POSITION_BITS)) u_axis_x
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl_x),
        .delta         (dx),
        .major         (major_reg),
        .preset        (preset),
        .allowed       (allowed_v[0]),
        .stepped       (stepped_v[0]),
        .phase_next    (ph_x),
        .position_next (pos_x)
    );

    tdsg_axis #(.STEP_BITS(STEP_BITS), .POSITION_BITS(POSITION_BITS)) u_axis_y
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl_y),
        .delta         (dy),
        .major         (major_reg),
        .preset        (preset),
        .allowed       (allowed_v[1]),
        .stepped       (stepped_v[1]),
        .phase_next    (ph_y),
        .position_next (pos_y)
    );

    tdsg_axis #(.STEP_BITS(STEP_BITS), .POSITION_BITS(POSITION_BITS)) u_axis_z
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl_z),
        .delta         (dz),
        .major         (major_reg),
        .preset        (preset),
        .allowed       (allowed_v[2]),
        .stepped       (stepped_v[2]),
        .phase_next    (ph_z),
        .position_next (pos_z)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // positions leave as their low 32 bits, zero-filled if narrower
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            x_phase    <= ph_x;
            y_phase    <= ph_y;
            z_phase    <= ph_z;
            stepped    <= stepped_v;
            moving     <= |allowed_v;
            x_position <= signed'(POS_OUT_W'(pos_x));
            y_position <= signed'(POS_OUT_W'(pos_y));
            z_position <= signed'(POS_OUT_W'(pos_z));
        end
    end

    assign out_valid = out_vld_reg;

    // ---------------- checks ----------------
    a_step_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((stepped & ~{3{moving}}) == 3'b000))
        else $error("axis stepped without being allowed");

    a_start_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && mode_reg != MODE_TICK) |=> (stepped == 3'b000 && !moving))
        else $error("non-tick item reported motion");

    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_vld_reg)
        else $error("processed item lost before result register");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled while pipeline can drain");

endmodule

// File: rtl/tdsg_axis.sv
// One DDA axis: remaining count, accumulator, Gray phase and position.
`timescale 1ns / 1ps

module tdsg_axis
    import tdsg_pkg::*;
#(
    parameter int STEP_BITS     = DEF_STEP_BITS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  axis_ctrl_t               ctrl,
    input  logic [STEP_BITS-1:0]     delta,
    input  logic [STEP_BITS-1:0]     major,
    input  logic [STEP_BITS+1:0]     preset,
    output logic                     allowed,
    output logic                     stepped,
    output logic [1:0]               phase_next,
    output logic [POSITION_BITS-1:0] position_next
);

    localparam int ACC_BITS = STEP_BITS + 2;

    logic [STEP_BITS-1:0]     remaining_reg, remaining_next;
    logic [ACC_BITS-1:0]      accum_reg, accum_next;
    logic [1:0]               phase_reg;
    logic [POSITION_BITS-1:0] position_reg;
    logic [ACC_BITS-1:0]      acc_sum;

    assign allowed = ctrl.tick && (remaining_reg != '0) && !ctrl.blocked;
    assign acc_sum = accum_reg + ACC_BITS'(delta);
    // step only on a strictly positive sum
    assign stepped = allowed && !acc_sum[ACC_BITS-1] && (acc_sum != '0);

    always_comb
    begin
        accum_next     = accum_reg;
        remaining_next = remaining_reg;
        phase_next     = phase_reg;
        position_next  = position_reg;
        if (ctrl.start)
        begin
            accum_next     = preset;
            remaining_next = delta;
        end
        else if (ctrl.zero)
        begin
            position_next = '0;
        end
        else if (allowed)
        begin
            accum_next = stepped ? (acc_sum - ACC_BITS'(major)) : acc_sum;
            if (stepped)
            begin
                remaining_next = remaining_reg - STEP_BITS'(1);
                position_next  = ctrl.dir ? (position_reg + POSITION_BITS'(1))
                                          : (position_reg - POSITION_BITS'(1));
                if (ctrl.drive)
                begin
                    phase_next = ctrl.dir ? phase_up(phase_reg) : phase_down(phase_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            accum_reg     <= '0;
            phase_reg     <= '0;
            position_reg  <= '0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            accum_reg     <= accum_next;
            phase_reg     <= phase_next;
            position_reg  <= position_next;
        end
    end

endmodule

// File: sim/three_axis_dda_step_generator_core_tb.sv
// Self-checking testbench for the three-axis DDA step generator core.
`timescale 1ns / 1ps

module three_axis_dda_step_generator_core_tb;
    import tdsg_pkg::*;

    // Generous bound: ~700 commands, random gaps and stalls, one long
    // hold-off and idle settling between config phases fit many times over.
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_WAIT  = 4;     // input and result registers, plus margin
    localparam int MAX_PRINTED  = 40;

    // Mode value the block ignores; index values that map to no register.
    localparam logic [1:0]           MODE_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;

    typedef struct {
        logic [1:0]  x_phase;
        logic [1:0]  y_phase;
        logic [1:0]  z_phase;
        logic [2:0]  stepped;
        logic        moving;
        logic [31:0] x_position;
        logic [31:0] y_position;
        logic [31:0] z_position;
    } step_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [1:0]                  mode = MODE_TICK;
    logic [2:0]                  limit_min = 3'd0;
    logic [2:0]                  limit_max = 3'd0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [1:0]                  x_phase;
    logic [1:0]                  y_phase;
    logic [1:0]                  z_phase;
    logic [2:0]                  stepped;
    logic                        moving;
    logic signed [POS_OUT_W-1:0] x_position;
    logic signed [POS_OUT_W-1:0] y_position;
    logic signed [POS_OUT_W-1:0] z_position;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_DELTA_X;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    three_axis_dda_step_generator_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .limit_min  (limit_min),
        .limit_max  (limit_max),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .x_phase    (x_phase),
        .y_phase    (y_phase),
        .z_phase    (z_phase),
        .stepped    (stepped),
        .moving     (moving),
        .x_position (x_position),
        .y_position (y_position),
        .z_position (z_position),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Interpolator mirror: live config plus per-axis DDA state.
    // Axis index 0 = x, 1 = y, 2 = z throughout.
    // ------------------------------------------------------------------
    logic [23:0] cfg_delta [3];
    logic [2:0]  cfg_dir;
    logic        cfg_z_en;
    logic        cfg_sw_low;

    logic [23:0] rem_steps [3];
    logic [25:0] acc [3];
    logic [23:0] major_count;
    logic [1:0]  ph [3];
    logic [31:0] pos [3];

    step_result_t awaited_steps [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;           // no random idling on either side
    int  hold_req = 0;           // bumped by a test to ask for a long hold-off
    int  hold_ack = 0;
    int  hold_cnt = 0;

    task automatic reset_mirror();
        for (int a = 0; a < 3; a++)
        begin
            cfg_delta[a] = '0;
            rem_steps[a] = '0;
            acc[a]       = '0;
            ph[a]        = '0;
            pos[a]       = '0;
        end
        cfg_dir     = '0;
        cfg_z_en    = 1'b1;
        cfg_sw_low  = 1'b1;
        major_count = '0;
    endtask

    // Gray sequence: forward 00 01 11 10, reverse 00 10 11 01.
    function automatic logic [1:0] gray_next(input logic [1:0] p, input logic fwd);
        logic [1:0] n;
        case (p)
            2'b00:   n = fwd ? 2'b01 : 2'b10;
            2'b01:   n = fwd ? 2'b11 : 2'b00;
            2'b11:   n = fwd ? 2'b10 : 2'b01;
            default: n = fwd ? 2'b00 : 2'b11;
        endcase
        return n;
    endfunction

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DELTA_X:    cfg_delta[0] = data[23:0];
            CFG_DELTA_Y:    cfg_delta[1] = data[23:0];
            CFG_DELTA_Z:    cfg_delta[2] = data[23:0];
            CFG_DIRECTION:  cfg_dir      = data[2:0];
            CFG_Z_OUT_EN:   cfg_z_en     = data[0];
            CFG_SW_ACT_LOW: cfg_sw_low   = data[0];
            default: ;
        endcase
    endtask

    // One axis of one tick. A pressed switch only blocks travel toward it.
    task automatic axis_tick(input int ax, input logic [2:0] lmin,
                             input logic [2:0] lmax, output logic allowed,
                             output logic took);
        logic       fwd;
        logic       hit;
        logic [25:0] sum;
        fwd     = cfg_dir[ax];
        hit     = fwd ? (lmax[ax] ^ cfg_sw_low) : (lmin[ax] ^ cfg_sw_low);
        allowed = 1'b0;
        took    = 1'b0;
        if (rem_steps[ax] != 0 && !hit)
        begin
            allowed = 1'b1;
            sum = acc[ax] + {2'b00, cfg_delta[ax]};
            // Zero counts as not positive: no step.
            if (sum[25] || sum == 26'd0)
                acc[ax] = sum;
            else
            begin
                took    = 1'b1;
                acc[ax] = sum - {2'b00, major_count};
                if (ax != 2 || cfg_z_en)
                    ph[ax] = gray_next(ph[ax], fwd);
                pos[ax]       = fwd ? pos[ax] + 32'd1 : pos[ax] - 32'd1;
                rem_steps[ax] = rem_steps[ax] - 24'd1;
            end
        end
    endtask

    task automatic predict_step_result(input logic [1:0] m, input logic [2:0] lmin,
                                       input logic [2:0] lmax);
        step_result_t r;
        logic [23:0]  big;
        logic [2:0]   ok;
        logic [2:0]   took;
        ok   = '0;
        took = '0;
        case (m)
            MODE_START:
            begin
                big = cfg_delta[0];
                if (cfg_delta[1] > big) big = cfg_delta[1];
                if (cfg_delta[2] > big) big = cfg_delta[2];
                major_count = big;
                for (int a = 0; a < 3; a++)
                begin
                    rem_steps[a] = cfg_delta[a];
                    acc[a]       = 26'd0 - {3'b000, big[23:1]};
                end
            end
            MODE_ZERO:
                for (int a = 0; a < 3; a++)
                    pos[a] = '0;
            MODE_TICK:
                for (int a = 0; a < 3; a++)
                    axis_tick(a, lmin, lmax, ok[a], took[a]);
            default: ;
        endcase
        r.x_phase    = ph[0];
        r.y_phase    = ph[1];
        r.z_phase    = ph[2];
        r.stepped    = took;
        r.moving     = |ok;
        r.x_position = pos[0];
        r.y_position = pos[1];
        r.z_position = pos[2];
        awaited_steps.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus plumbing. All calls start just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one command and hold it until the block takes the transfer.
    task automatic offer_command(input logic [1:0] m, input logic [2:0] lmin,
                                 input logic [2:0] lmax);
        while (!quiet && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        limit_min <= lmin;
        limit_max <= lmax;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_step_result(m, lmin, lmax);
    endtask

    // Drop valid and wait until every awaited result is back and the
    // pipeline has had time to empty.
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Switch levels that read as released under the current polarity.
    function automatic logic [2:0] released_levels();
        return cfg_sw_low ? 3'b111 : 3'b000;
    endfunction

    function automatic logic [23:0] pick_delta();
        logic [23:0] d;
        case ($urandom_range(9))
            0:       d = 24'd0;
            1:       d = 24'hFFFFFF;
            2:       d = 24'd1;
            3:       d = $urandom;
            default: d = $urandom_range(1, 48);
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("ERROR t=%0t result %0d %s: got 0x%0h, want 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: no move loaded, so nothing may step; reserved mode and
    // position clear must leave everything at zero.
    task automatic test_power_on();
        offer_command(MODE_TICK, 3'b000, 3'b000);
        offer_command(MODE_RESERVED, 3'b111, 3'b111);
        offer_command(MODE_ZERO, 3'b111, 3'b000);
    endtask

    // Largest x delta drives a huge major count; all axes forward, active-low
    // switches. Max switches pressed must freeze the move, min switches not.
    task automatic test_full_scale_move();
        write_register(CFG_DELTA_X, 24'hFFFFFF);
        write_register(CFG_DELTA_Y, 24'd1);
        write_register(CFG_DELTA_Z, 24'h800000);
        write_register(CFG_DIRECTION, 24'd7);
        write_register(CFG_Z_OUT_EN, 24'd1);
        write_register(CFG_SW_ACT_LOW, 24'd1);
        offer_command(MODE_START, 3'b111, 3'b111);
        repeat (3) offer_command(MODE_TICK, 3'b111, 3'b111);
        offer_command(MODE_TICK, 3'b111, 3'b000);
        offer_command(MODE_TICK, 3'b000, 3'b111);
        offer_command(MODE_TICK, 3'b101, 3'b010);
    endtask

    // Short reverse move with active-high switches and z pins disabled:
    // z still counts position, its phase must hold. Runs to completion.
    task automatic test_reverse_move();
        write_register(CFG_DELTA_X, 24'd3);
        write_register(CFG_DELTA_Y, 24'd5);
        write_register(CFG_DELTA_Z, 24'd5);
        write_register(CFG_DIRECTION, 24'd0);
        write_register(CFG_Z_OUT_EN, 24'd0);
        write_register(CFG_SW_ACT_LOW, 24'd0);
        offer_command(MODE_START, 3'b000, 3'b000);
        offer_command(MODE_TICK, 3'b111, 3'b000);
        offer_command(MODE_TICK, 3'b000, 3'b111);
        repeat (5) offer_command(MODE_TICK, 3'b000, 3'b000);
        offer_command(MODE_RESERVED, 3'b000, 3'b000);
        offer_command(MODE_ZERO, 3'b000, 3'b000);
        repeat (2) offer_command(MODE_TICK, 3'b000, 3'b000);
    endtask

    // Random moves: mostly start followed by a run of ticks with switches
    // released, with pressed switches, clears and restarts mixed in. Some
    // phases skip the start so new deltas act on a move already under way.
    task automatic test_random_moves(input int phases);
        int          n_ticks;
        int          roll;
        logic [2:0]  lmin;
        logic [2:0]  lmax;
        for (int p = 0; p < phases; p++)
        begin
            quiet = (p == 2 || p == 3);
            if ($urandom_range(9) < 7) write_register(CFG_DELTA_X, pick_delta());
            if ($urandom_range(9) < 7) write_register(CFG_DELTA_Y, pick_delta());
            if ($urandom_range(9) < 7) write_register(CFG_DELTA_Z, pick_delta());
            if ($urandom_range(9) < 7) write_register(CFG_DIRECTION, $urandom);
            if ($urandom_range(9) < 3) write_register(CFG_Z_OUT_EN, $urandom);
            if ($urandom_range(9) < 3) write_register(CFG_SW_ACT_LOW, $urandom);
            if ($urandom_range(9) == 0)
                write_register($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
            if ($urandom_range(9) < 8)
                offer_command(MODE_START, $urandom, $urandom);
            n_ticks = $urandom_range(20, 60);
            for (int k = 0; k < n_ticks; k++)
            begin
                roll = $urandom_range(99);
                lmin = released_levels();
                lmax = released_levels();
                if (roll < 3)
                    offer_command(MODE_ZERO, $urandom, $urandom);
                else if (roll < 5)
                    offer_command(MODE_RESERVED, $urandom, $urandom);
                else if (roll < 7)
                    offer_command(MODE_START, $urandom, $urandom);
                else
                begin
                    if (roll < 22)
                    begin
                        lmin = $urandom;
                        lmax = $urandom;
                    end
                    offer_command(MODE_TICK, lmin, lmax);
                end
            end
        end
        quiet = 1'b0;
    endtask

    // Result side holds off for a long stretch while ticks keep coming, so
    // the block fills and must stall its input without losing anything.
    task automatic test_result_hold();
        write_register(CFG_DELTA_X, 24'd40);
        write_register(CFG_DELTA_Y, 24'd17);
        write_register(CFG_DELTA_Z, 24'd29);
        quiet = 1'b1;
        offer_command(MODE_START, released_levels(), released_levels());
        hold_req++;
        repeat (40) offer_command(MODE_TICK, released_levels(), released_levels());
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus the long hold-off when asked.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_cnt  <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 15);
    end

    // Every result transfer is matched against the oldest awaited one.
    always @(posedge clk)
    begin : check_results
        step_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_steps.size() == 0)
                report_mismatch("result with none awaited", 32'd0, 32'd0);
            else
            begin
                want = awaited_steps.pop_front();
                if (x_phase !== want.x_phase)
                    report_mismatch("x_phase", x_phase, want.x_phase);
                if (y_phase !== want.y_phase)
                    report_mismatch("y_phase", y_phase, want.y_phase);
                if (z_phase !== want.z_phase)
                    report_mismatch("z_phase", z_phase, want.z_phase);
                if (stepped !== want.stepped)
                    report_mismatch("stepped", stepped, want.stepped);
                if (moving !== want.moving)
                    report_mismatch("moving", moving, want.moving);
                if (x_position !== want.x_position)
                    report_mismatch("x_position", x_position, want.x_position);
                if (y_position !== want.y_position)
                    report_mismatch("y_position", y_position, want.y_position);
                if (z_position !== want.z_position)
                    report_mismatch("z_position", z_position, want.z_position);
            end
            results_seen++;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TIMEOUT after %0d cycles, %0d results awaited",
                     cycle_count, awaited_steps.size());
            $display("three_axis_dda_step_generator_core verification failed");
            $finish;
        end
    end

    initial
    begin
        reset_mirror();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_full_scale_move();
        test_reverse_move();
        test_random_moves(8);
        test_result_hold();
        test_random_moves(8);
        settle_idle();

        if (mismatch_count == 0 && awaited_steps.size() == 0)
            $display("three_axis_dda_step_generator_core verification clean");
        else
            $display("three_axis_dda_step_generator_core verification failed");
        $finish;
    end

endmodule
